/* rtl/core/lsb_first_bit_field_unpacker_unit_defines.svh */
// Assertion macros for the LSB-first bit field unpacker.
// Used by the top level; the clock and reset names are those of that module.
`ifndef LSB_FIRST_BIT_FIELD_UNPACKER_UNIT_DEFINES_SVH
`define LSB_FIRST_BIT_FIELD_UNPACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBFU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lbfu_pkg.sv */
// Shared constants, codes and types of the LSB-first bit field unpacker.
// No dependencies.
`timescale 1ns / 1ps

package lbfu_pkg;

    localparam int WORD_W    = 32;
    localparam int CFG_W     = 11;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 6;
    localparam int STAT_W    = 2;
    localparam int MAX_WORDS = 256;
    localparam int ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PTR_W     = $clog2(MAX_WORDS + 1);
    localparam int SCR_W     = 64;
    localparam int FILL_W    = 7;
    localparam int CONS_W    = 14;
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD    = 2'd0,
        K_READ    = 2'd1,
        K_ALIGN   = 2'd2,
        K_RESTART = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_READ,
        OP_ALIGN,
        OP_RESTART,
        OP_BADCNT
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERRUN  = 2'd1,
        ST_PADDING  = 2'd2,
        ST_BADCOUNT = 2'd3
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic              issue_fire;
        logic              exec_pending;
        logic [PTR_W-1:0]  load_ptr;
        logic [PTR_W-1:0]  fetch_idx;
    } t_back_status;

endpackage

/* rtl/core/lbfu_if.sv */
// Valid/ready channel interfaces for the input items and the result words.
// Depends on lbfu_pkg for the field widths.
`timescale 1ns / 1ps

interface lbfu_in_if;
    import lbfu_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word_data;
    logic [CNT_W-1:0]  bit_count;

    modport source (output valid, kind, word_data, bit_count, input ready);
    modport sink   (input valid, kind, word_data, bit_count, output ready);
endinterface

interface lbfu_out_if;
    import lbfu_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] field_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, field_value, status, input ready);
    modport sink   (input valid, field_value, status, output ready);
endinterface

/* rtl/core/lbfu_front.sv */
// Front end: accepts input words and classifies them into queue entries.
// Depends on lbfu_pkg and lbfu_in_if.
`timescale 1ns / 1ps

module lbfu_front (
    lbfu_in_if.sink          i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output lbfu_pkg::t_entry o_entry
);
    import lbfu_pkg::*;

    logic bad_count;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign bad_count  = (i_in.bit_count == '0) || (i_in.bit_count > CNT_W'(WORD_W));

    always_comb begin
        o_entry.data  = i_in.word_data;
        o_entry.count = i_in.bit_count;
        case (t_kind'(i_in.kind))
            K_LOAD:    o_entry.op = OP_LOAD;
            K_READ:    o_entry.op = bad_count ? OP_BADCNT : OP_READ;
            K_ALIGN:   o_entry.op = OP_ALIGN;
            K_RESTART: o_entry.op = OP_RESTART;
            default:   o_entry.op = OP_RESTART;
        endcase
    end

endmodule

/* rtl/core/lbfu_queue.sv */
// Two-entry queue between the front end and the execution back end.
// Depends on lbfu_pkg.
`timescale 1ns / 1ps

module lbfu_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lbfu_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output lbfu_pkg::t_entry    o_head,
    output lbfu_pkg::t_q_status o_status
);
    import lbfu_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/core/lbfu_back.sv */
// Back end: word store, scratch register, read positions and result register.
// Depends on lbfu_pkg and lbfu_out_if.
`timescale 1ns / 1ps

module lbfu_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [lbfu_pkg::CFG_W-1:0] i_cfg_data,
    input  lbfu_pkg::t_entry         i_head,
    input  lbfu_pkg::t_q_status      i_q_status,
    output logic                     o_pop,
    output lbfu_pkg::t_back_status   o_status,
    lbfu_out_if.source               o_out
);
    import lbfu_pkg::*;

    typedef enum logic [1:0] {
        BS_ISSUE = 2'b01,
        BS_EXEC  = 2'b10
    } t_back_state;

    logic [WORD_W-1:0] r_store [MAX_WORDS];

    t_back_state       r_state;
    t_back_state       n_state;
    t_entry            r_op;
    logic [WORD_W-1:0] r_rd_data;
    logic [CFG_W-1:0]  r_stream_bytes;
    logic [PTR_W-1:0]  r_load_ptr;
    logic [PTR_W-1:0]  n_load_ptr;
    logic [PTR_W-1:0]  r_fetch_idx;
    logic [PTR_W-1:0]  n_fetch_idx;
    logic [SCR_W-1:0]  r_scratch;
    logic [SCR_W-1:0]  n_scratch;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [CONS_W-1:0] r_consumed;
    logic [CONS_W-1:0] n_consumed;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_value;
    t_status           r_out_status;
    logic [WORD_W-1:0] res_value;
    t_status           res_status;

    logic              issue_fire;
    logic              exec_fire;
    logic              store_wr;
    logic [CNT_W-1:0]  take_n;
    logic [CONS_W:0]   take_sum;
    logic [CONS_W:0]   take_limit;
    logic              need_refill;
    logic              take_ok;
    logic [SCR_W-1:0]  take_scr;
    logic [SCR_W-1:0]  take_mask;
    logic [WORD_W-1:0] take_val;
    logic [FILL_W-1:0] take_fill;

    assign issue_fire = (r_state == BS_ISSUE) && !i_q_status.empty;
    assign exec_fire  = (r_state == BS_EXEC) && (!r_out_valid || o_out.ready);
    assign o_pop      = issue_fire;

    assign o_status.issue_fire   = issue_fire;
    assign o_status.exec_pending = (r_state == BS_EXEC);
    assign o_status.load_ptr     = r_load_ptr;
    assign o_status.fetch_idx    = r_fetch_idx;

    assign o_out.valid       = r_out_valid;
    assign o_out.field_value = r_out_value;
    assign o_out.status      = r_out_status;

    always_comb begin
        if (r_op.op == OP_ALIGN) begin
            take_n = CNT_W'(8) - CNT_W'(r_consumed[2:0]);
        end else begin
            take_n = r_op.count;
        end
        take_sum    = {1'b0, r_consumed} + (CONS_W + 1)'(take_n);
        take_limit  = {1'b0, r_stream_bytes, 3'b000};
        need_refill = (r_fill < FILL_W'(take_n));
        take_ok     = (take_sum <= take_limit) &&
                      !(need_refill && (r_fetch_idx >= r_load_ptr));
        if (need_refill) begin
            take_scr  = r_scratch | ({{(SCR_W - WORD_W){1'b0}}, r_rd_data} << r_fill);
            take_fill = r_fill + FILL_W'(WORD_W) - FILL_W'(take_n);
        end else begin
            take_scr  = r_scratch;
            take_fill = r_fill - FILL_W'(take_n);
        end
        take_mask = (SCR_W'(1) << take_n) - SCR_W'(1);
        take_val  = take_scr[WORD_W-1:0] & take_mask[WORD_W-1:0];
    end

    always_comb begin
        n_load_ptr  = r_load_ptr;
        n_fetch_idx = r_fetch_idx;
        n_scratch   = r_scratch;
        n_fill      = r_fill;
        n_consumed  = r_consumed;
        res_value   = '0;
        res_status  = ST_OK;
        store_wr    = 1'b0;
        case (r_op.op)
            OP_LOAD: begin
                if (r_load_ptr < PTR_W'(MAX_WORDS)) begin
                    n_load_ptr = r_load_ptr + 1'b1;
                    store_wr   = 1'b1;
                end else begin
                    res_status = ST_OVERRUN;
                end
            end
            OP_READ, OP_ALIGN: begin
                if ((r_op.op == OP_ALIGN) && (r_consumed[2:0] == 3'd0)) begin
                    res_status = ST_OK;
                end else if (!take_ok) begin
                    res_status = ST_OVERRUN;
                end else begin
                    n_scratch  = take_scr >> take_n;
                    n_fill     = take_fill;
                    n_consumed = take_sum[CONS_W-1:0];
                    if (need_refill) begin
                        n_fetch_idx = r_fetch_idx + 1'b1;
                    end
                    if (r_op.op == OP_READ) begin
                        res_value = take_val;
                    end else if (take_val != '0) begin
                        res_value  = take_val;
                        res_status = ST_PADDING;
                    end
                end
            end
            OP_RESTART: begin
                n_load_ptr  = '0;
                n_fetch_idx = '0;
                n_scratch   = '0;
                n_fill      = '0;
                n_consumed  = '0;
            end
            OP_BADCNT: begin
                res_status = ST_BADCOUNT;
            end
            default: begin
                res_status = ST_BADCOUNT;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_ISSUE: begin
                if (issue_fire) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if (exec_fire) begin
                    n_state = BS_ISSUE;
                end
            end
            default: n_state = BS_ISSUE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BS_ISSUE;
            r_stream_bytes <= '0;
            r_load_ptr     <= '0;
            r_fetch_idx    <= '0;
            r_scratch      <= '0;
            r_fill         <= '0;
            r_consumed     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_stream_bytes <= i_cfg_data;
            end
            if (exec_fire) begin
                r_load_ptr  <= n_load_ptr;
                r_fetch_idx <= n_fetch_idx;
                r_scratch   <= n_scratch;
                r_fill      <= n_fill;
                r_consumed  <= n_consumed;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_fire) begin
            r_op      <= i_head;
            r_rd_data <= r_store[r_fetch_idx[ADDR_W-1:0]];
        end
        if (exec_fire) begin
            r_out_value  <= res_value;
            r_out_status <= res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire && store_wr) begin
            r_store[r_load_ptr[ADDR_W-1:0]] <= r_op.data;
        end
    end

endmodule

/* rtl/core/lsb_first_bit_field_unpacker_unit.sv */
// LSB-first bit field unpacker, top level. Depends on lbfu_pkg, lbfu_if,
// lbfu_front, lbfu_queue, lbfu_back and the assertion macro header.
// Input words on i_in carry a kind: load a 32-bit word into the store, read
// 1 to 32 bits least significant bit first, align to the next byte, or restart.
// Every input word gives exactly one result word on o_out: the field value
// and a status code. The byte count of the stream is written on the config
// channel (i_cfg_valid, i_cfg_data, o_cfg_ready, always ready); the user
// must write it only while idle, the block itself does not enforce this.
// An accepted word lands in a two-entry queue; the execution side takes one
// entry at a time (issue for the registered word store read, then execute)
// and no new one until it has executed. When o_out stalls, the result
// register holds one finished word and the queue keeps accepting until full.
// Reset clears the queue, read and load positions, scratch and the byte
// count; the word store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "lsb_first_bit_field_unpacker_unit_defines.svh"

module lsb_first_bit_field_unpacker_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lbfu_in_if.sink                    i_in,
    lbfu_out_if.source                 o_out,
    input  logic                       i_cfg_valid,
    input  logic [lbfu_pkg::CFG_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);
    import lbfu_pkg::*;

    logic         push;
    logic         pop;
    t_entry       push_entry;
    t_entry       head;
    t_q_status    q_stat;
    t_back_status back_stat;

    assign o_cfg_ready = 1'b1;

    lbfu_front u_front (
        .i_in     (i_in),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    lbfu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_stat)
    );

    lbfu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .i_q_status  (q_stat),
        .o_pop       (pop),
        .o_status    (back_stat),
        .o_out       (o_out)
    );

    `LBFU_ASSERT_IMPLY(a_fetch_le_load, 1'b1, back_stat.fetch_idx <= back_stat.load_ptr, "fetch index passed load pointer")
    `LBFU_ASSERT_IMPLY(a_load_le_max, 1'b1, back_stat.load_ptr <= PTR_W'(MAX_WORDS), "load pointer beyond store depth")
    `LBFU_ASSERT_IMPLY(a_full_not_ready, q_stat.full, !i_in.ready, "input ready while queue full")
    `LBFU_ASSERT_NEXT(a_issue_to_exec, back_stat.issue_fire, back_stat.exec_pending, "issued word not pending execution")

endmodule
